// File: src/vnd_pkg.sv
package vnd_pkg;

  // Reduction mode codes held in the mode register.
  localparam logic [2:0] MODE_SUM_ABS      = 3'd0;
  localparam logic [2:0] MODE_TWO_NORM     = 3'd1;
  localparam logic [2:0] MODE_MAX_ABS      = 3'd2;
  localparam logic [2:0] MODE_DIFF_SUM_ABS = 3'd3;
  localparam logic [2:0] MODE_DIFF_TWO     = 3'd4;
  localparam logic [2:0] MODE_DIFF_MAX     = 3'd5;
  localparam logic [2:0] MODE_DOT          = 3'd6;
  localparam logic [2:0] MODE_UNUSED       = 3'd7;

  // Field widths.
  localparam int unsigned ElemWidth = 32;
  localparam int unsigned AccWidth  = 64;
  localparam int unsigned ModeWidth = 3;

  // The square root retires two radicand bits per step.
  localparam int unsigned RootSteps = AccWidth / 2;
  localparam int unsigned RootCntW  = $clog2(RootSteps);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_ACC,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval_en;
    logic mul_en;
    logic acc_en;
    logic root_init;
    logic root_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic root_mode;
  } status_t;

endpackage

// File: src/vector_norm_dot_reduction.sv
// Streaming vector norm and dot product over signed Q16.16 element pairs.
// Input channel: in_valid_i / in_stall_o carry one element pair per beat,
// with last_element_i marking the final pair of a vector. Output channel:
// out_valid_o / out_stall_i carry one result per vector, norm_value_o
// (Q16.16 for norms, Q32.32 for the dot product) and the sticky
// saturated_o flag. The mode is written through cfg_we_i / cfg_data_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Each element beat passes through capture,
// difference and absolute value, the shared 33x33 multiplier, then the
// saturating accumulate; the next pair is stalled until it is accumulated.
// A last beat then loads the output register once the output slot is free;
// the two-norm modes first run the iterative root, one result bit per cycle.
// Reset clears the mode to sum of absolute values, the accumulator, the
// sticky flag and the output valid. A stalled result holds in the output
// register while the next vector streams in; only the next result waits
// for the receiver to take it.
module vector_norm_dot_reduction (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] norm_value_o,
  output logic               saturated_o
);
  import vnd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  vnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  vnd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .last_element_i (last_element_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .norm_value_o   (norm_value_o),
    .saturated_o    (saturated_o)
  );

endmodule

// File: src/vnd_ctrl.sv
module vnd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  vnd_pkg::status_t status_i,
  output vnd_pkg::cmd_t    cmd_o
);
  import vnd_pkg::*;

  state_e              state_q, state_d;
  logic [RootCntW-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // The output slot can take a new result when empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  // State, step counter and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval_en = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.root_mode) begin
          state_d = ST_ROOT_INIT;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == RootCntW'(RootSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/vnd_datapath.sv
module vnd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_data_i,
  input  logic signed [31:0]   first_value_i,
  input  logic signed [31:0]   second_value_i,
  input  logic                 last_element_i,
  input  vnd_pkg::cmd_t        cmd_i,
  output vnd_pkg::status_t     status_o,
  output logic signed [63:0]   norm_value_o,
  output logic                 saturated_o
);
  import vnd_pkg::*;

  localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  logic [ModeWidth-1:0]        mode_q;
  logic signed [ElemWidth-1:0] u_q, v_q;
  logic                        last_q;
  logic [ElemWidth-1:0]        ax_q, ax_d;
  logic signed [AccWidth-1:0]  prod_q, prod_d;
  logic signed [AccWidth-1:0]  acc_q, acc_d;
  logic                        ovf_q, ovf_d;
  logic [AccWidth-1:0]         rem_q, root_q, bit_q;
  logic signed [AccWidth-1:0]  norm_q;
  logic                        sat_q;

  logic diff_mode, square_mode, max_mode, sum_mode, root_mode;

  // Mode decode.
  assign diff_mode   = (mode_q == MODE_DIFF_SUM_ABS) || (mode_q == MODE_DIFF_TWO) ||
                       (mode_q == MODE_DIFF_MAX);
  assign square_mode = (mode_q == MODE_TWO_NORM) || (mode_q == MODE_DIFF_TWO);
  assign max_mode    = (mode_q == MODE_MAX_ABS) || (mode_q == MODE_DIFF_MAX);
  assign sum_mode    = (mode_q == MODE_SUM_ABS) || (mode_q == MODE_DIFF_SUM_ABS) ||
                       square_mode || (mode_q == MODE_DOT);
  assign root_mode   = square_mode;

  assign status_o.last      = last_q;
  assign status_o.root_mode = root_mode;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUM_ABS;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Input beat capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      u_q    <= first_value_i;
      v_q    <= second_value_i;
      last_q <= last_element_i;
    end
  end

  // Saturated difference and absolute value.
  logic signed [ElemWidth:0]   diff;
  logic                        diff_hi, diff_lo;
  logic signed [ElemWidth-1:0] x_sel;
  logic [ElemWidth:0]          x_ext, x_abs;

  always_comb begin
    diff    = {u_q[ElemWidth-1], u_q} - {v_q[ElemWidth-1], v_q};
    diff_hi = !diff[ElemWidth] && diff[ElemWidth-1];
    diff_lo = diff[ElemWidth] && !diff[ElemWidth-1];
    if (!diff_mode) begin
      x_sel = u_q;
    end else if (diff_hi) begin
      x_sel = {1'b0, {(ElemWidth-1){1'b1}}};
    end else if (diff_lo) begin
      x_sel = {1'b1, {(ElemWidth-1){1'b0}}};
    end else begin
      x_sel = diff[ElemWidth-1:0];
    end
    x_ext = {x_sel[ElemWidth-1], x_sel};
    x_abs = x_sel[ElemWidth-1] ? (~x_ext + 1'b1) : x_ext;
    ax_d  = x_abs[ElemWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_en) begin
      ax_q <= ax_d;
    end
  end

  // Shared multiplier: signed product for the dot product, square otherwise.
  logic signed [ElemWidth:0]     op_a, op_b;
  logic signed [2*ElemWidth+1:0] prod_full;

  always_comb begin
    if (mode_q == MODE_DOT) begin
      op_a = {u_q[ElemWidth-1], u_q};
      op_b = {v_q[ElemWidth-1], v_q};
    end else begin
      op_a = {1'b0, ax_q};
      op_b = {1'b0, ax_q};
    end
    prod_full = op_a * op_b;
    if (square_mode || (mode_q == MODE_DOT)) begin
      prod_d = prod_full[AccWidth-1:0];
    end else begin
      prod_d = {{(AccWidth-ElemWidth){1'b0}}, ax_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Saturating accumulate or running maximum, plus the sticky flag.
  logic signed [AccWidth:0] sum;
  logic                     sum_ovf;

  always_comb begin
    sum     = {acc_q[AccWidth-1], acc_q} + {prod_q[AccWidth-1], prod_q};
    sum_ovf = sum[AccWidth] != sum[AccWidth-1];
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    if (cmd_i.eval_en && diff_mode && (diff_hi || diff_lo)) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.acc_en) begin
      if (sum_mode) begin
        if (sum_ovf) begin
          acc_d = sum[AccWidth] ? AccMin : AccMax;
          ovf_d = 1'b1;
        end else begin
          acc_d = sum[AccWidth-1:0];
        end
      end else if (max_mode) begin
        if (prod_q > acc_q) begin
          acc_d = prod_q;
        end
      end
    end
    if (cmd_i.load_out) begin
      acc_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
    end
  end

  // Digit-by-digit square root, one result bit per step.
  logic [AccWidth-1:0] trial;
  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rem_q  <= (acc_q > 0) ? acc_q : '0;
      root_q <= '0;
      bit_q  <= {2'b01, {(AccWidth-2){1'b0}}};
    end else if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (root_mode) begin
        norm_q <= root_q;
      end else if (mode_q == MODE_UNUSED) begin
        norm_q <= '0;
      end else begin
        norm_q <= acc_q;
      end
      sat_q <= ovf_q;
    end
  end

  assign norm_value_o = norm_q;
  assign saturated_o  = sat_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vnd_pkg::*;

  localparam logic signed [31:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;

  // Cycles to let pass once nothing is expected: element pipe, output load
  // and the square root, with margin.
  localparam int SettleCycles = 60;
  localparam int HoldCycles   = 300;
  localparam int HoldAfter    = 60;
  localparam int RandomItems  = 1100;

  typedef struct {
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               last;
  } elem_pair_t;

  typedef struct {
    logic signed [63:0] norm;
    logic               sat;
  } norm_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_data_i = MODE_SUM_ABS;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] first_value_i = '0;
  logic signed [31:0] second_value_i = '0;
  logic               last_element_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [63:0] norm_value_o;
  logic               saturated_o;

  // Element pairs waiting to be offered, and norms waiting to come out.
  elem_pair_t   pending_pairs[$];
  norm_result_t expected_norms[$];

  // Copy of the block's state as predicted.
  logic [2:0]         mode_reg = MODE_SUM_ABS;
  logic signed [63:0] running_sum = '0;
  logic               sticky_sat = 1'b0;

  int send_idle_pct = 7;
  int recv_idle_pct = 47;
  int mismatch_count = 0;
  int norms_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  elem_pair_t   next_pair;
  norm_result_t want;

  vector_norm_dot_reduction DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .norm_value_o   (norm_value_o),
    .saturated_o    (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // Saturating 64-bit add; any clamp sets the sticky flag.
  function automatic logic signed [63:0] add_saturating(input logic signed [63:0] lhs,
                                                        input logic signed [63:0] rhs);
    logic [64:0] wide;
    wide = {lhs[63], lhs} + {rhs[63], rhs};
    if (wide[64] != wide[63]) begin
      sticky_sat = 1'b1;
      return wide[64] ? ACC_MIN : ACC_MAX;
    end
    return wide[63:0];
  endfunction

  // Floor of the square root; zero for a non-positive radicand.
  function automatic logic signed [63:0] floor_sqrt(input logic signed [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    if (radicand <= 0) return '0;
    rem = radicand;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Fold one accepted element pair into the predicted state; a last beat
  // queues the expected norm and clears the state.
  function automatic void accumulate_pair(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic last);
    logic [32:0]        wide_diff;
    logic signed [63:0] elem;
    logic signed [63:0] mag;
    logic signed [63:0] ext_a;
    logic signed [63:0] ext_b;
    norm_result_t       res;
    ext_a = {{32{a[31]}}, a};
    ext_b = {{32{b[31]}}, b};
    elem = ext_a;
    if (mode_reg >= MODE_DIFF_SUM_ABS && mode_reg <= MODE_DIFF_MAX) begin
      wide_diff = {a[31], a} - {b[31], b};
      if (wide_diff[32] != wide_diff[31]) begin
        sticky_sat = 1'b1;
        elem = wide_diff[32] ? {{32{1'b1}}, ELEM_MIN} : {32'd0, ELEM_MAX};
      end else begin
        elem = {{32{wide_diff[31]}}, wide_diff[31:0]};
      end
    end
    mag = elem[63] ? -elem : elem;
    case (mode_reg)
      MODE_SUM_ABS, MODE_DIFF_SUM_ABS: running_sum = add_saturating(running_sum, mag);
      MODE_TWO_NORM, MODE_DIFF_TWO: running_sum = add_saturating(running_sum, mag * mag);
      MODE_MAX_ABS, MODE_DIFF_MAX: begin
        if (mag > running_sum) running_sum = mag;
      end
      MODE_DOT: running_sum = add_saturating(running_sum, ext_a * ext_b);
      default: ;
    endcase
    if (last) begin
      if (mode_reg == MODE_TWO_NORM || mode_reg == MODE_DIFF_TWO) begin
        res.norm = floor_sqrt(running_sum);
      end else if (mode_reg == MODE_UNUSED) begin
        res.norm = '0;
      end else begin
        res.norm = running_sum;
      end
      res.sat = sticky_sat;
      expected_norms.push_back(res);
      running_sum = '0;
      sticky_sat = 1'b0;
    end
  endfunction

  // Element values weighted toward the extremes.
  function automatic logic signed [31:0] pick_element();
    case ($urandom_range(9))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return '0;
      3: return -32'sd1;
      4, 5: return 32'(int'($urandom_range(2047)) - 1024) <<< 12;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic last);
    elem_pair_t p;
    p.first = a;
    p.second = b;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  // Wait until every pair is accepted and every norm has come out, then
  // let the pipeline drain before touching the mode register.
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid_i || expected_norms.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic change_mode(input logic [2:0] mode);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_reg = mode;
  endtask

  // Random vectors in one mode; sometimes the last vector is left open so
  // that the next mode takes over its running value.
  task automatic random_phase(input logic [2:0] mode, input int n_items);
    int sent;
    int len;
    change_mode(mode);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        push_pair(pick_element(), pick_element(), i == len - 1);
      end
      sent += len;
    end
    if ($urandom_range(3) == 0) push_pair(pick_element(), pick_element(), 1'b0);
  endtask

  // Driver: offers queued pairs and predicts each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_pair(first_value_i, second_value_i, last_element_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair = pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          first_value_i <= next_pair.first;
          second_value_i <= next_pair.second;
          last_element_i <= next_pair.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted norm and drives the output stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        norms_seen++;
        if (expected_norms.size() == 0) begin
          $display("%0t: unexpected beat: norm %0d saturated %0b", $time,
                   norm_value_o, saturated_o);
          mismatch_count++;
        end else begin
          want = expected_norms.pop_front();
          if (norm_value_o !== want.norm) begin
            $display("%0t: norm_value expected %0d actual %0d", $time, want.norm,
                     norm_value_o);
            mismatch_count++;
          end
          if (saturated_o !== want.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                     saturated_o);
            mismatch_count++;
          end
        end
      end
      // One long hold-off while the sender still has plenty to offer.
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && norms_seen >= HoldAfter && pending_pairs.size() > 20) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sum of absolute values from the reset mode.
    push_pair(ELEM_MAX, '0, 1'b0);
    push_pair(ELEM_MIN, '0, 1'b1);
    push_pair('0, ELEM_MIN, 1'b1);
    // Two-norm with a saturating sum of squares, then an exact root.
    change_mode(MODE_TWO_NORM);
    push_pair(ELEM_MIN, '0, 1'b0);
    push_pair(ELEM_MIN, '0, 1'b1);
    push_pair(3 * ONE_Q16, '0, 1'b1);
    change_mode(MODE_MAX_ABS);
    push_pair(-32'sd5, '0, 1'b0);
    push_pair(ELEM_MIN, '0, 1'b1);
    // Differences that clamp in both directions.
    change_mode(MODE_DIFF_SUM_ABS);
    push_pair(ELEM_MAX, ELEM_MIN, 1'b1);
    push_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    change_mode(MODE_DIFF_TWO);
    push_pair(ONE_Q16, -ONE_Q16, 1'b1);
    change_mode(MODE_DIFF_MAX);
    push_pair(-32'sd100, 32'sd50, 1'b0);
    push_pair('0, ELEM_MAX, 1'b1);
    // Dot product saturating high, then low.
    change_mode(MODE_DOT);
    push_pair(ELEM_MIN, ELEM_MIN, 1'b0);
    push_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    push_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    push_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    push_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    // A negative dot product finished as a two-norm gives a zero root.
    push_pair(-ONE_Q16, ONE_Q16, 1'b0);
    change_mode(MODE_TWO_NORM);
    push_pair('0, '0, 1'b1);
    // The unused mode reports zero but keeps the sticky flag.
    change_mode(MODE_DIFF_SUM_ABS);
    push_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    change_mode(MODE_UNUSED);
    push_pair(32'sd5, 32'sd5, 1'b1);
    push_pair(32'sd1, 32'sd2, 1'b1);

    // Random vectors: every mode under each idle pattern.
    for (int p = 0; p < 3; p++) begin
      wait_drained();
      send_idle_pct = (p == 0) ? 7 : (p == 1) ? 47 : 0;
      recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 7 : 0;
      for (int k = 0; k < 8; k++) begin
        random_phase(3'((k + 3 * p) % 8), RandomItems / 24);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
src/vnd_pkg.sv
src/vnd_ctrl.sv
src/vnd_datapath.sv
src/vector_norm_dot_reduction.sv
dv/testbench.sv
